// ===== design/bcn_texture_block_decoder_assert.svh =====
`ifndef BCN_TEXTURE_BLOCK_DECODER_ASSERT_SVH
`define BCN_TEXTURE_BLOCK_DECODER_ASSERT_SVH

// Check a consequence in the same cycle as its cause.
`define BCN_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause.
`define BCN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bcn_tbd_pkg.sv =====
package bcn_tbd_pkg;

    localparam logic [1:0] FMT_BC1 = 2'd0;
    localparam logic [1:0] FMT_BC2 = 2'd1;
    localparam logic [1:0] FMT_BC3 = 2'd2;

    localparam int unsigned PIX_PER_BLOCK = 16;

    typedef struct packed {
        logic [63:0] color_block;
        logic [63:0] alpha_block;
    } t_in_item;

    typedef struct packed {
        logic [3:0] pixel_number;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       uses_alpha;
        logic       last;
    } t_out_item;

    function automatic logic [7:0] expand5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [7:0] expand6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

    // Truncating x/3 for x <= 765 by reciprocal multiply.
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [20:0] p;
        p = 21'(x) * 21'd683;
        return p[18:11];
    endfunction

    // Truncating x/5 for x <= 1275.
    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [23:0] p;
        p = 24'(x) * 24'd1639;
        return p[20:13];
    endfunction

    // Truncating x/7 for x <= 1785.
    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [24:0] p;
        p = 25'(x) * 25'd2341;
        return p[21:14];
    endfunction

endpackage

// ===== design/bcn_texture_block_decoder.sv =====
// Channel   Signals                                    Direction
// in        i_in_valid, i_in_data, o_in_stall          block in (color + alpha words)
// out       o_out_valid, o_out_data, i_out_stall       one RGBA pixel out
// cfg       i_cfg_valid, i_cfg_data, o_cfg_ready       format register write
//
// Pixels move one per cycle, while the output does not stall, from the block register
// through the palette logic into the output register, in the order of the pixel counter.
// A new block is taken in the cycle its last pixel moves to the output register,
// so blocks stream with no gap. An accepted block is held in the block register first.
// A stall on the output holds the output register and the pixel counter.
// Reset is synchronous, active low; it clears the format to BC1 and all valids.
module bcn_texture_block_decoder
    import bcn_tbd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_in_item   i_in_data,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output t_out_item  o_out_data,
    input  logic       i_out_stall,
    input  logic       i_cfg_valid,
    input  logic [1:0] i_cfg_data,
    output logic       o_cfg_ready
);

`include "bcn_texture_block_decoder_assert.svh"

    logic [1:0]  r_fmt;
    logic        r_blk_vld, n_blk_vld;
    t_in_item    r_blk;
    logic [3:0]  r_pix, n_pix;
    logic        r_out_vld, n_out_vld;
    t_out_item   r_out;

    logic        out_free;
    logic        pix_load;
    logic        in_acc;

    logic [15:0] e0, e1;
    logic        is_bc1, is_bc2, three_mode;
    logic [7:0]  ep0 [3];
    logic [7:0]  ep1 [3];
    logic [7:0]  pal [4][3];
    logic [7:0]  a0, a1;
    logic [7:0]  apal [8];
    logic [31:0] cidx_bits;
    logic [1:0]  ci;
    logic [47:0] aidx_bits;
    logic [5:0]  aidx_pos;
    logic [2:0]  ai;
    logic [3:0]  a4;
    logic [7:0]  alpha;

    assign o_cfg_ready = 1'b1;

    assign out_free   = !r_out_vld || !i_out_stall;
    assign pix_load   = r_blk_vld && out_free;
    assign o_in_stall = r_blk_vld && !(out_free && r_pix == 4'(PIX_PER_BLOCK - 1));
    assign in_acc     = i_in_valid && !o_in_stall;

    // Palette construction from the held block.
    assign e0         = r_blk.color_block[15:0];
    assign e1         = r_blk.color_block[31:16];
    assign is_bc1     = (r_fmt == FMT_BC1);
    assign is_bc2     = (r_fmt == FMT_BC2);
    assign three_mode = is_bc1 && !(e0 > e1);

    assign ep0[0] = expand5(e0[15:11]);
    assign ep0[1] = expand6(e0[10:5]);
    assign ep0[2] = expand5(e0[4:0]);
    assign ep1[0] = expand5(e1[15:11]);
    assign ep1[1] = expand6(e1[10:5]);
    assign ep1[2] = expand5(e1[4:0]);

    always_comb begin
        logic [8:0] half_sum;
        for (int ch = 0; ch < 3; ch++) begin
            half_sum   = {1'b0, ep0[ch]} + {1'b0, ep1[ch]};
            pal[0][ch] = ep0[ch];
            pal[1][ch] = ep1[ch];
            if (three_mode) begin
                pal[2][ch] = half_sum[8:1];
                pal[3][ch] = 8'd0;
            end else begin
                pal[2][ch] = div3({1'b0, ep0[ch], 1'b0} + {2'b00, ep1[ch]});
                pal[3][ch] = div3({2'b00, ep0[ch]} + {1'b0, ep1[ch], 1'b0});
            end
        end
    end

    assign a0 = r_blk.alpha_block[7:0];
    assign a1 = r_blk.alpha_block[15:8];

    always_comb begin
        apal[0] = a0;
        apal[1] = a1;
        for (int k = 2; k < 8; k++) begin
            if (a0 > a1) begin
                apal[k] = div7(11'(8 - k) * {3'b000, a0} + 11'(k - 1) * {3'b000, a1});
            end else if (k < 6) begin
                apal[k] = div5(11'(6 - k) * {3'b000, a0} + 11'(k - 1) * {3'b000, a1});
            end else if (k == 6) begin
                apal[k] = 8'd0;
            end else begin
                apal[k] = 8'd255;
            end
        end
    end

    // Pick the current pixel.
    assign cidx_bits = r_blk.color_block[63:32];
    assign ci        = cidx_bits[{r_pix, 1'b0} +: 2];
    assign a4        = r_blk.alpha_block[{r_pix, 2'b00} +: 4];
    assign aidx_bits = r_blk.alpha_block[63:16];
    assign aidx_pos  = {2'b00, r_pix} + {1'b0, r_pix, 1'b0};
    assign ai        = aidx_bits[aidx_pos +: 3];

    always_comb begin
        if (is_bc1) begin
            alpha = (three_mode && ci == 2'd3) ? 8'd0 : 8'd255;
        end else if (is_bc2) begin
            alpha = {a4, a4};
        end else begin
            alpha = apal[ai];
        end
    end

    // Control: advance the pixel counter on each load, take a new block on the last or when none is held.
    always_comb begin
        n_blk_vld = r_blk_vld;
        n_pix     = r_pix;
        n_out_vld = r_out_vld;
        if (out_free) begin
            n_out_vld = r_blk_vld;
        end
        if (pix_load) begin
            n_pix = r_pix + 4'd1;
            if (r_pix == 4'(PIX_PER_BLOCK - 1)) begin
                n_blk_vld = 1'b0;
            end
        end
        if (in_acc) begin
            n_blk_vld = 1'b1;
            n_pix     = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt     <= FMT_BC1;
            r_blk_vld <= 1'b0;
            r_pix     <= 4'd0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_fmt <= i_cfg_data;
            end
            r_blk_vld <= n_blk_vld;
            r_pix     <= n_pix;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_blk <= i_in_data;
        end
        if (pix_load) begin
            r_out.pixel_number <= r_pix;
            r_out.red          <= pal[ci][0];
            r_out.green        <= pal[ci][1];
            r_out.blue         <= pal[ci][2];
            r_out.alpha        <= alpha;
            r_out.uses_alpha   <= is_bc1 ? three_mode : 1'b1;
            r_out.last         <= (r_pix == 4'(PIX_PER_BLOCK - 1));
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    `BCN_ASSERT_NEXT(a_acc_restart, in_acc, r_blk_vld && r_pix == 4'd0,
        "accepted block did not restart the pixel counter")
    `BCN_ASSERT_NOW(a_take_on_last, r_blk_vld && !o_in_stall,
        r_pix == 4'(PIX_PER_BLOCK - 1) && out_free,
        "block taken before the held block finished")
    `BCN_ASSERT_NOW(a_block_pending, r_out_vld && !r_out.last, r_blk_vld,
        "pixel shown without its block held")
    `BCN_ASSERT_NEXT(a_pixel_order, o_out_valid && !i_out_stall && !o_out_data.last,
        o_out_valid && o_out_data.pixel_number == $past(o_out_data.pixel_number) + 4'd1,
        "pixel sequence broken")

endmodule
